@@ rtl/core/xrlz_pkg.sv @@
// Shared constants, types and the byte decryption function of the XOR-rotate LZ78 decoder.
package xrlz_pkg;

	localparam int DICT_ENTRIES = 4096;
	localparam int MAX_PHRASE   = 64;

	localparam int DICT_AW  = $clog2(DICT_ENTRIES);
	localparam int NFI_W    = DICT_AW + 1;
	localparam int STACK_AW = $clog2(MAX_PHRASE);
	localparam int LEN_W    = $clog2(MAX_PHRASE + 1);

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_XOR_KEY    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATE_AMT = 1'd1;

	// result status codes
	localparam logic [1:0] ST_DATA      = 2'd0;
	localparam logic [1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [1:0] ST_TOO_LONG  = 2'd2;
	localparam logic [1:0] ST_TRUNCATED = 2'd3;

	// token byte position
	localparam logic [1:0] PH_IDX_LO = 2'd0;
	localparam logic [1:0] PH_IDX_HI = 2'd1;
	localparam logic [1:0] PH_SYMBOL = 2'd2;

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_LOOK    = 7'b0000010,
		S_WALK    = 7'b0000100,
		S_EMIT_RD = 7'b0001000,
		S_EMIT    = 7'b0010000,
		S_SYM     = 7'b0100000,
		S_ERR     = 7'b1000000
	} state_t;

	typedef struct packed {
		logic [DICT_AW-1:0] parent;
		logic [7:0]         symbol;
		logic [LEN_W-1:0]   length;
	} dict_entry_t;

	// XOR with the key, then rotate right
	function automatic logic [7:0] decrypt(input logic [7:0] raw, input logic [7:0] key,
			input logic [2:0] rot);
		logic [15:0] dbl;
		logic [7:0]  b;
		b   = raw ^ key;
		dbl = {b, b} >> rot;
		return dbl[7:0];
	endfunction

endpackage

@@ rtl/core/xrlz_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module xrlz_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, data holds while idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/xor_rotate_lz78_decoder_unit.sv @@
// Top level of the XOR-rotate LZ78 decoder: token parsing, dictionary walk and result output.
//
// Each incoming byte is XORed with the key and rotated right, and every three decoded bytes
// form a token (phrase index low byte, high byte, symbol). Index bytes produce no result
// unless the stream ends on one. A symbol byte starts the token work: one dictionary read for
// the indexed entry, then one read per remaining entry of the chain walk, paced by the
// dictionary RAM's registered read, then the phrase bytes read back from the phrase stack,
// then the symbol; the emit and symbol steps wait while the result register is full. Index
// zero emits only the symbol. Errors give one result with a nonzero status and last set,
// after which input beats are dropped until a beat with start_stream. No clearing pass is
// needed after reset.
module xor_rotate_lz78_decoder_unit
	import xrlz_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] data_byte
	input  logic                 s_tuser,   // [0] start_stream
	input  logic                 s_tlast,   // end_of_stream
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // [7:0] out_byte
	output logic [1:0]           m_tuser,   // [1:0] status
	output logic                 m_tlast,   // last
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	state_t state_q, state_d;

	logic [7:0]       xor_key_q;
	logic [2:0]       rotate_q;
	logic [NFI_W-1:0] next_free_q;
	logic [1:0]       phase_q;
	logic [7:0]       idx_lo_q;
	logic [15:0]      idx_q;
	logic             err_q;
	logic [7:0]       sym_q;
	logic [LEN_W-1:0] plen_q;
	logic [LEN_W-1:0] cnt_q;
	logic [LEN_W-1:0] ptr_q;
	logic [1:0]       err_code_q;

	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic [1:0]       out_status_q;
	logic             out_last_q;

	logic             in_beat;
	logic             slot_free;
	logic             start_eff_err;
	logic [1:0]       eff_phase;
	logic [NFI_W-1:0] eff_nf;
	logic [7:0]       dec_byte;
	logic             dict_full;

	logic             dict_re;
	logic [DICT_AW-1:0] dict_raddr;
	logic             dict_we;
	dict_entry_t      dict_wdata;
	dict_entry_t      dict_rdata;
	logic [$bits(dict_entry_t)-1:0] dict_rdata_raw;

	logic             stk_we;
	logic [STACK_AW-1:0] stk_waddr;
	logic             stk_re;
	logic [STACK_AW-1:0] stk_raddr;
	logic [7:0]       stk_rdata;

	logic [LEN_W-1:0] len_dec;
	logic [LEN_W-1:0] cnt_dec;
	logic [LEN_W-1:0] ptr_inc;

	logic             out_load;
	logic [7:0]       out_byte_d;
	logic [1:0]       out_status_d;
	logic             out_last_d;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign in_beat   = s_tvalid && s_tready;
	assign slot_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

	// a start beat clears stream state before the byte is used
	assign start_eff_err = s_tuser ? 1'b0 : err_q;
	assign eff_phase     = s_tuser ? PH_IDX_LO : phase_q;
	assign eff_nf        = s_tuser ? NFI_W'(1) : next_free_q;
	assign dec_byte      = decrypt(s_tdata, xor_key_q, rotate_q);
	assign dict_full     = (next_free_q >= NFI_W'(DICT_ENTRIES));

	assign dict_rdata = dict_entry_t'(dict_rdata_raw);
	assign len_dec    = dict_rdata.length - LEN_W'(1);
	assign cnt_dec    = cnt_q - LEN_W'(1);
	assign ptr_inc    = ptr_q + LEN_W'(1);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_key_q <= 8'd0;
			rotate_q  <= 3'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_XOR_KEY:    xor_key_q <= cfg_data;
				REG_ROTATE_AMT: rotate_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// control: next state, memory ports and result load
	always_comb begin
		state_d      = state_q;
		dict_re      = 1'b0;
		dict_raddr   = dict_rdata.parent;
		dict_we      = 1'b0;
		dict_wdata   = '{parent: idx_q[DICT_AW-1:0], symbol: sym_q, length: plen_q + LEN_W'(1)};
		stk_we       = 1'b0;
		stk_waddr    = cnt_dec[STACK_AW-1:0];
		stk_re       = 1'b0;
		stk_raddr    = ptr_q[STACK_AW-1:0];
		out_load     = 1'b0;
		out_byte_d   = stk_rdata;
		out_status_d = ST_DATA;
		out_last_d   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_beat && !start_eff_err) begin
					if (eff_phase == PH_IDX_LO || eff_phase == PH_IDX_HI) begin
						if (s_tlast) begin
							state_d = S_ERR;
						end
					end else if (32'(idx_q) >= 32'(eff_nf)) begin
						state_d = S_ERR;
					end else if (idx_q == 16'd0) begin
						state_d = S_SYM;
					end else begin
						dict_re    = 1'b1;
						dict_raddr = idx_q[DICT_AW-1:0];
						state_d    = S_LOOK;
					end
				end
			end
			S_LOOK: begin
				if (dict_rdata.length >= LEN_W'(MAX_PHRASE)) begin
					state_d = S_ERR;
				end else begin
					stk_we    = 1'b1;
					stk_waddr = len_dec[STACK_AW-1:0];
					if (len_dec == '0) begin
						state_d = S_EMIT_RD;
					end else begin
						dict_re = 1'b1;
						state_d = S_WALK;
					end
				end
			end
			S_WALK: begin
				stk_we = 1'b1;
				if (cnt_dec == '0) begin
					state_d = S_EMIT_RD;
				end else begin
					dict_re = 1'b1;
				end
			end
			S_EMIT_RD: begin
				stk_re  = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (slot_free) begin
					out_load = 1'b1;
					if (ptr_inc == plen_q) begin
						state_d = S_SYM;
					end else begin
						stk_re    = 1'b1;
						stk_raddr = ptr_inc[STACK_AW-1:0];
					end
				end
			end
			S_SYM: begin
				if (slot_free) begin
					out_load   = 1'b1;
					out_byte_d = sym_q;
					out_last_d = 1'b1;
					dict_we    = !dict_full;
					state_d    = S_IDLE;
				end
			end
			S_ERR: begin
				if (slot_free) begin
					out_load     = 1'b1;
					out_byte_d   = 8'd0;
					out_status_d = err_code_q;
					out_last_d   = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and token registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			next_free_q <= NFI_W'(1);
			phase_q     <= PH_IDX_LO;
			idx_lo_q    <= 8'd0;
			idx_q       <= 16'd0;
			err_q       <= 1'b0;
			err_code_q  <= ST_DATA;
			sym_q       <= 8'd0;
			plen_q      <= '0;
			cnt_q       <= '0;
			ptr_q       <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						// clear stream state on start
						if (s_tuser) begin
							next_free_q <= NFI_W'(1);
							phase_q     <= PH_IDX_LO;
							idx_lo_q    <= 8'd0;
							idx_q       <= 16'd0;
							err_q       <= 1'b0;
						end
						if (!start_eff_err) begin
							unique case (eff_phase)
								PH_IDX_LO: begin
									idx_lo_q   <= dec_byte;
									phase_q    <= PH_IDX_HI;
									err_code_q <= ST_TRUNCATED;
								end
								PH_IDX_HI: begin
									idx_q      <= {dec_byte, (s_tuser ? 8'd0 : idx_lo_q)};
									phase_q    <= PH_SYMBOL;
									err_code_q <= ST_TRUNCATED;
								end
								default: begin
									phase_q    <= PH_IDX_LO;
									sym_q      <= dec_byte;
									plen_q     <= '0;
									err_code_q <= ST_BAD_INDEX;
								end
							endcase
						end
					end
				end
				S_LOOK: begin
					plen_q     <= dict_rdata.length;
					cnt_q      <= len_dec;
					ptr_q      <= '0;
					err_code_q <= ST_TOO_LONG;
				end
				S_WALK: begin
					cnt_q <= cnt_dec;
				end
				S_EMIT: begin
					if (slot_free) begin
						ptr_q <= ptr_inc;
					end
				end
				S_SYM: begin
					// add the new phrase while there is room
					if (slot_free && !dict_full) begin
						next_free_q <= next_free_q + NFI_W'(1);
					end
				end
				S_ERR: begin
					if (slot_free) begin
						err_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// result register: load a new beat while the old one leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q   <= out_byte_d;
			out_status_q <= out_status_d;
			out_last_q   <= out_last_d;
		end
	end

	// dictionary: parent, symbol and length per entry
	xrlz_ram #(
		.WIDTH($bits(dict_entry_t)),
		.DEPTH(DICT_ENTRIES)
	) u_dict (
		.clk   (clk),
		.we    (dict_we),
		.waddr (next_free_q[DICT_AW-1:0]),
		.wdata (dict_wdata),
		.re    (dict_re),
		.raddr (dict_raddr),
		.rdata (dict_rdata_raw)
	);

	// phrase stack: chain bytes stored tail first, read back head first
	xrlz_ram #(
		.WIDTH(8),
		.DEPTH(MAX_PHRASE)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (dict_rdata.symbol),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// error results always close the item
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_DATA) |-> (m_tlast && m_tdata == 8'd0))
		else $error("error beat without last or with data");

	// the next free index stays within 1..DICT_ENTRIES
	a_nf_range: assert property (@(posedge clk) disable iff (!arst_n)
		(next_free_q != '0) && (next_free_q <= NFI_W'(DICT_ENTRIES)))
		else $error("next free index out of range");

	// the walk never runs past the head of the chain
	a_walk_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (cnt_q != '0))
		else $error("chain walk with nothing left to store");

	// emitted phrases fit the stack
	a_emit_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT || state_q == S_EMIT_RD) |-> (plen_q < LEN_W'(MAX_PHRASE)
			&& ptr_q < plen_q))
		else $error("phrase read beyond its length");

	// a delivered error latches
	a_err_latch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ERR && slot_free) |=> err_q)
		else $error("error not latched");

endmodule

@@ dv/xor_rotate_lz78_decoder_unit_test.sv @@
// Self-checking testbench for the XOR-rotate LZ78 decoder unit with a built-in decode predictor.
module xor_rotate_lz78_decoder_unit_test;
	import xrlz_pkg::*;

	localparam int SETTLE_CYCLES = 150;
	localparam int RANDOM_BEATS  = 40;
	localparam int RUN_LIMIT     = 4000000;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] status;
		logic       last;
	} lz_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;
	logic                 s_tuser;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [7:0]           m_tdata;
	logic [1:0]           m_tuser;
	logic                 m_tlast;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;

	// shadow copy of the decoder state and settings
	logic [DICT_AW-1:0] dict_parent [DICT_ENTRIES];
	logic [7:0]         dict_symbol [DICT_ENTRIES];
	logic [LEN_W-1:0]   dict_len    [DICT_ENTRIES];
	logic [NFI_W-1:0]   free_idx;
	logic [1:0]         tok_phase;
	logic [7:0]         idx_lo;
	logic [15:0]        idx_word;
	logic               err_latched;
	logic [7:0]         key_q;
	logic [2:0]         rot_q;

	// decoded bytes and error codes still owed by the block, oldest first
	lz_result_t expected_q[$];

	int fail_count    = 0;
	int beats_sent    = 0;
	int results_seen  = 0;
	int error_results = 0;
	int send_idle_max = 15;
	int recv_idle_max = 15;
	int recv_stall    = 0;
	int recv_hold     = 0;

	xor_rotate_lz78_decoder_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#RUN_LIMIT;
		$display("FAILURE");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void reset_model();
		key_q       = 8'h00;
		rot_q       = 3'd1;
		free_idx    = NFI_W'(1);
		tok_phase   = PH_IDX_LO;
		idx_lo      = 8'h00;
		idx_word    = 16'h0000;
		err_latched = 1'b0;
	endfunction

	// undo the cipher: XOR with the key, then rotate right one bit at a time
	function automatic logic [7:0] decrypt_byte(input logic [7:0] raw);
		logic [7:0] b;
		int         i;
		b = raw ^ key_q;
		for (i = 0; i < rot_q; i++)
			b = {b[0], b[7:1]};
		return b;
	endfunction

	// apply the cipher so that the block decodes the wanted byte
	function automatic logic [7:0] encrypt_byte(input logic [7:0] plain);
		logic [7:0] b;
		int         i;
		b = plain;
		for (i = 0; i < rot_q; i++)
			b = {b[6:0], b[7]};
		return b ^ key_q;
	endfunction

	function automatic void push_result(input logic [7:0] data, input logic [1:0] status,
			input logic last);
		lz_result_t r;
		r.data   = data;
		r.status = status;
		r.last   = last;
		expected_q.push_back(r);
	endfunction

	// one error beat, then drop input until the next stream start
	function automatic void raise_error(input logic [1:0] code);
		push_result(8'h00, code, 1'b1);
		err_latched = 1'b1;
		error_results++;
	endfunction

	// emit the stored phrase and the symbol, then grow the dictionary
	function automatic void expand_token(input logic [15:0] idx, input logic [7:0] sym);
		int                 plen;
		int                 pos;
		int                 i;
		logic [DICT_AW-1:0] node;
		logic [7:0]         phrase [MAX_PHRASE];
		if (idx >= free_idx || idx >= DICT_ENTRIES) begin
			raise_error(ST_BAD_INDEX);
			return;
		end
		plen = (idx == 0) ? 0 : int'(dict_len[idx[DICT_AW-1:0]]);
		if (plen + 1 > MAX_PHRASE) begin
			raise_error(ST_TOO_LONG);
			return;
		end
		node = idx[DICT_AW-1:0];
		pos  = plen;
		while (pos > 0 && node != 0) begin
			pos--;
			phrase[pos] = dict_symbol[node];
			node        = dict_parent[node];
		end
		for (i = 0; i < plen; i++)
			push_result(phrase[i], ST_DATA, 1'b0);
		push_result(sym, ST_DATA, 1'b1);
		if (free_idx < DICT_ENTRIES) begin
			dict_parent[free_idx[DICT_AW-1:0]] = idx[DICT_AW-1:0];
			dict_symbol[free_idx[DICT_AW-1:0]] = sym;
			dict_len[free_idx[DICT_AW-1:0]]    = LEN_W'(plen + 1);
			free_idx++;
		end
	endfunction

	// advance the token parser by one accepted beat; returns 0 when the beat is dropped
	function automatic bit decode_beat(input logic start, input logic [7:0] raw, input logic eos);
		logic [7:0] b;
		if (start) begin
			free_idx    = NFI_W'(1);
			tok_phase   = PH_IDX_LO;
			idx_lo      = 8'h00;
			idx_word    = 16'h0000;
			err_latched = 1'b0;
		end
		if (err_latched)
			return 1'b0;
		b = decrypt_byte(raw);
		case (tok_phase)
			PH_IDX_LO: begin
				idx_lo    = b;
				tok_phase = PH_IDX_HI;
				if (eos)
					raise_error(ST_TRUNCATED);
			end
			PH_IDX_HI: begin
				idx_word  = {b, idx_lo};
				tok_phase = PH_SYMBOL;
				if (eos)
					raise_error(ST_TRUNCATED);
			end
			default: begin
				tok_phase = PH_IDX_LO;
				expand_token(idx_word, b);
			end
		endcase
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------- result side

	// hold off for a requested stretch, else stall per result as drawn by the checker
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (recv_hold > 0) begin
				m_tready <= 1'b0;
				recv_hold--;
			end else if (recv_stall > 0) begin
				m_tready <= 1'b0;
				recv_stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin : check_results
		lz_result_t want;
		if (m_tvalid && m_tready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				$error("result beat with nothing expected: out_byte %h status %0d last %0b",
					m_tdata, m_tuser, m_tlast);
				fail_count++;
			end else begin
				want = expected_q.pop_front();
				if (m_tdata !== want.data) begin
					$error("out_byte: expected %h, got %h", want.data, m_tdata);
					fail_count++;
				end
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					fail_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, m_tlast);
					fail_count++;
				end
			end
			recv_stall = $urandom_range(0, recv_idle_max);
		end
	end

	// ---------------------------------------------------------------- drivers

	// offer one input beat after a random gap and wait until it is taken
	task automatic send_beat(input logic start, input logic [7:0] raw, input logic eos);
		int gap;
		gap = $urandom_range(0, send_idle_max);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= start;
		s_tdata  <= raw;
		s_tlast  <= eos;
		do @(posedge clk); while (!s_tready);
		if (decode_beat(start, raw, eos))
			beats_sent++;
	endtask

	// three beats: index low byte, index high byte, symbol
	task automatic send_token(input logic start, input logic [15:0] idx, input logic [7:0] sym,
			input logic eos);
		send_beat(start, encrypt_byte(idx[7:0]), 1'b0);
		send_beat(1'b0, encrypt_byte(idx[15:8]), 1'b0);
		send_beat(1'b0, encrypt_byte(sym), eos);
	endtask

	// stop offering and let every owed result drain, plus time for silent work
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_XOR_KEY)
			key_q = value;
		else
			rot_q = value[2:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input logic [7:0] key, input logic [7:0] rot);
		wait_idle();
		write_reg(REG_XOR_KEY, key);
		write_reg(REG_ROTATE_AMT, rot);
	endtask

	// ---------------------------------------------------------------- tests

	// reset settings: literal symbols, phrase reuse, clean end and carrying on after it
	task automatic test_basic_tokens();
		send_token(1'b1, 16'h0000, 8'h00, 1'b0);
		send_token(1'b0, 16'h0001, 8'hFF, 1'b0);
		send_token(1'b0, 16'h0002, 8'hA5, 1'b1);
		send_token(1'b0, 16'h0003, 8'h3C, 1'b0);
	endtask

	// index beyond the dictionary, latched error, restart
	task automatic test_bad_index();
		send_token(1'b1, 16'hFFFF, 8'h11, 1'b0);
		send_beat(1'b0, 8'h00, 1'b1);
		send_token(1'b1, 16'h0001, 8'h22, 1'b0);
	endtask

	// stream ending inside a token, and a restart in the middle of one
	task automatic test_truncated();
		send_beat(1'b1, encrypt_byte(8'h00), 1'b1);
		send_beat(1'b1, encrypt_byte(8'h00), 1'b0);
		send_beat(1'b0, encrypt_byte(8'h00), 1'b1);
		send_beat(1'b1, encrypt_byte(8'h00), 1'b0);
		send_beat(1'b1, encrypt_byte(8'h00), 1'b0);
		send_beat(1'b0, encrypt_byte(8'h00), 1'b0);
		send_beat(1'b0, encrypt_byte(8'h7E), 1'b1);
	endtask

	// sweep key and rotation, extremes first
	task automatic test_key_and_rotation();
		int s;
		for (s = 0; s < 4; s++) begin
			case (s)
				0: set_config(8'h00, 8'h00);
				1: set_config(8'hFF, 8'h07);
				// rotation value wider than its field
				2: set_config(8'h5A, 8'hFD);
				default: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 7)));
			endcase
			send_token(1'b1, 16'h0000, s[0] ? 8'hFF : 8'h00, 1'b0);
			send_token(1'b0, 16'h0001, 8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	// chain up to the longest phrase, then one step past it
	task automatic test_phrase_too_long();
		int k;
		set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 7)));
		for (k = 0; k < MAX_PHRASE; k++)
			send_token(k == 0, 16'(k), 8'($urandom_range(0, 255)), 1'b0);
		send_token(1'b0, 16'(MAX_PHRASE), 8'($urandom_range(0, 255)), 1'b1);
	endtask

	// long output stall while long phrases keep coming, then drain
	task automatic test_backpressure();
		int k;
		wait_idle();
		send_idle_max = 0;
		for (k = 0; k < 10; k++)
			send_token(k == 0, 16'(k), 8'($urandom_range(0, 255)), 1'b0);
		recv_hold = 400;
		repeat (6) send_token(1'b0, 16'd10, 8'($urandom_range(0, 255)), 1'b0);
		wait_idle();
		send_idle_max = 15;
	endtask

	// mostly well-formed streams with random content, some noise and broken tails
	task automatic test_random_streams();
		int  first_beat;
		int  ntok;
		int  pick;
		int  idx;
		int  avail;
		int  t;
		int  n;
		int  i;
		bit  do_start;
		first_beat = beats_sent;
		while (beats_sent - first_beat < RANDOM_BEATS) begin
			if ($urandom_range(0, 4) == 0)
				set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			send_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
			recv_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
			if ($urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++)
					send_beat($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)),
						$urandom_range(0, 7) == 0);
			end else begin
				ntok     = $urandom_range(1, 12);
				do_start = err_latched || $urandom_range(0, 3) == 0;
				for (t = 0; t < ntok; t++) begin
					avail = (t == 0 && do_start) ? 1 : int'(free_idx);
					pick  = $urandom_range(0, 19);
					// favor the newest entry so phrases grow long
					if (pick < 11)
						idx = avail - 1;
					else if (pick < 16)
						idx = $urandom_range(0, avail - 1);
					else if (pick < 18)
						idx = 0;
					else
						idx = $urandom_range(avail, 16'hFFFF);
					send_token(t == 0 && do_start, 16'(idx), 8'($urandom_range(0, 255)),
						t == ntok - 1 && $urandom_range(0, 2) != 0);
				end
				if ($urandom_range(0, 5) == 0) begin
					n = $urandom_range(1, 2);
					for (i = 0; i < n; i++)
						send_beat(1'b0, 8'($urandom_range(0, 255)), i == n - 1);
				end
			end
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		s_tvalid  = 1'b0;
		s_tdata   = 8'h00;
		s_tuser   = 1'b0;
		s_tlast   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_XOR_KEY;
		cfg_data  = 8'h00;
		arst_n    = 1'b0;
		reset_model();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_basic_tokens();
		test_bad_index();
		test_truncated();
		test_key_and_rotation();
		test_phrase_too_long();
		test_backpressure();
		test_random_streams();
		wait_idle();

		$display("Decoded %0d input beats into %0d checked result beats, %0d of them errors.",
			beats_sent, results_seen, error_results);
		$display("Covered key/rotation sweeps, the phrase length limit and a long output stall.");
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ xor_rotate_lz78_decoder_unit.f @@
rtl/core/xrlz_pkg.sv
rtl/core/xrlz_ram.sv
rtl/core/xor_rotate_lz78_decoder_unit.sv
dv/xor_rotate_lz78_decoder_unit_test.sv
